@@ design/tlv_element_header_encoder_assert.svh @@
// ----------------------------------------------------------------------------
// TLV element header encoder assertion macros
// Shared concurrent assertion forms used by the encoder modules.
// ----------------------------------------------------------------------------
`ifndef TLV_ELEMENT_HEADER_ENCODER_ASSERT_SVH
`define TLV_ELEMENT_HEADER_ENCODER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, disabled while rst_ni is low.
`define TLV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, disabled while rst_ni is low.
`define TLV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/tlv_enc_pkg.sv @@
// ----------------------------------------------------------------------------
// TLV encoder package
// Types, codes and the VAR-NUMBER encoding function shared by the encoder.
// ----------------------------------------------------------------------------
package tlv_enc_pkg;

  // Operation codes.
  localparam logic [1:0] OpHeader  = 2'd0;
  localparam logic [1:0] OpInteger = 2'd1;
  localparam logic [1:0] OpRestart = 2'd2;

  // Result status codes.
  localparam logic [1:0] StatusByte    = 2'd0;
  localparam logic [1:0] StatusNoFit   = 2'd1;
  localparam logic [1:0] StatusRestart = 2'd2;

  localparam logic [15:0] CapacityReset = 16'd8192;
  localparam logic [7:0]  Mark2         = 8'd253;
  localparam logic [7:0]  Mark4         = 8'd254;
  localparam logic [7:0]  OneByteLimit  = 8'd253;

  localparam int unsigned MaxBytes = 10;
  localparam int unsigned CountW   = 4;

  typedef struct packed {
    logic [1:0]  op;
    logic [30:0] elem_type;
    logic [31:0] length;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  // One queued element: its bytes in memory order (entry 0 leaves first).
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CountW-1:0]        count;
    logic [1:0]               status;
  } desc_t;

  typedef struct packed {
    logic [4:0][7:0] bytes;
    logic [2:0]      len;
  } vn_t;

  function automatic vn_t varnum(logic [31:0] v);
    vn_t r;
    r.bytes = '0;
    if (v < {24'd0, OneByteLimit}) begin
      r.bytes[0] = v[7:0];
      r.len      = 3'd1;
    end else if (v[31:16] == 16'd0) begin
      r.bytes[0] = Mark2;
      r.bytes[1] = v[15:8];
      r.bytes[2] = v[7:0];
      r.len      = 3'd3;
    end else begin
      r.bytes[0] = Mark4;
      r.bytes[1] = v[31:24];
      r.bytes[2] = v[23:16];
      r.bytes[3] = v[15:8];
      r.bytes[4] = v[7:0];
      r.len      = 3'd5;
    end
    return r;
  endfunction

endpackage

@@ design/tlv_enc_front.sv @@
// ----------------------------------------------------------------------------
// TLV encoder front end
// Accepts items, builds the element bytes and keeps the free-space count.
// ----------------------------------------------------------------------------
module tlv_enc_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [15:0]           cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  tlv_enc_pkg::in_item_t in_data_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output tlv_enc_pkg::desc_t    q_data_o
);

  logic [15:0] capacity_q, capacity_d;
  logic [15:0] free_q, free_d;

  logic                        in_fire;
  tlv_enc_pkg::vn_t            type_vn;
  tlv_enc_pkg::vn_t            sec_vn;
  logic [tlv_enc_pkg::CountW-1:0] total;
  logic                        fits;
  logic [tlv_enc_pkg::MaxBytes*8-1:0] packed_bytes;

  assign in_ready_o = !q_full_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    type_vn = tlv_enc_pkg::varnum({1'b0, in_data_i.elem_type});
    sec_vn  = '0;
    case (in_data_i.op)
      tlv_enc_pkg::OpHeader: begin
        sec_vn = tlv_enc_pkg::varnum(in_data_i.length);
      end
      tlv_enc_pkg::OpInteger: begin
        // Length byte, then the value padded to 1, 2 or 4 bytes, big-endian.
        if (in_data_i.value[31:16] != 16'd0) begin
          sec_vn.bytes[0] = 8'd4;
          sec_vn.bytes[1] = in_data_i.value[31:24];
          sec_vn.bytes[2] = in_data_i.value[23:16];
          sec_vn.bytes[3] = in_data_i.value[15:8];
          sec_vn.bytes[4] = in_data_i.value[7:0];
          sec_vn.len      = 3'd5;
        end else if (in_data_i.value[15:8] != 8'd0) begin
          sec_vn.bytes[0] = 8'd2;
          sec_vn.bytes[1] = in_data_i.value[15:8];
          sec_vn.bytes[2] = in_data_i.value[7:0];
          sec_vn.len      = 3'd3;
        end else begin
          sec_vn.bytes[0] = 8'd1;
          sec_vn.bytes[1] = in_data_i.value[7:0];
          sec_vn.len      = 3'd2;
        end
      end
      default: begin
        sec_vn = '0;
      end
    endcase
  end

  // The second part starts right after the type bytes.
  assign packed_bytes = ((tlv_enc_pkg::MaxBytes*8)'(sec_vn.bytes) << {type_vn.len, 3'b000})
                      | (tlv_enc_pkg::MaxBytes*8)'(type_vn.bytes);
  assign total = tlv_enc_pkg::CountW'(type_vn.len) + tlv_enc_pkg::CountW'(sec_vn.len);
  assign fits  = {12'd0, total} <= free_q;

  always_comb begin
    capacity_d = capacity_q;
    free_d     = free_q;
    q_push_o   = 1'b0;
    q_data_o   = '0;
    q_data_o.count = tlv_enc_pkg::CountW'(1);
    if (cfg_we_i) begin
      capacity_d = cfg_wdata_i;
    end
    if (in_fire) begin
      case (in_data_i.op)
        tlv_enc_pkg::OpRestart: begin
          free_d          = capacity_q;
          q_push_o        = 1'b1;
          q_data_o.status = tlv_enc_pkg::StatusRestart;
        end
        tlv_enc_pkg::OpHeader, tlv_enc_pkg::OpInteger: begin
          q_push_o = 1'b1;
          if (fits) begin
            free_d          = free_q - {12'd0, total};
            q_data_o.bytes  = packed_bytes;
            q_data_o.count  = total;
            q_data_o.status = tlv_enc_pkg::StatusByte;
          end else begin
            q_data_o.status = tlv_enc_pkg::StatusNoFit;
          end
        end
        default: begin
          q_push_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= tlv_enc_pkg::CapacityReset;
      free_q     <= tlv_enc_pkg::CapacityReset;
    end else begin
      capacity_q <= capacity_d;
      free_q     <= free_d;
    end
  end

`include "tlv_element_header_encoder_assert.svh"

  `TLV_ASSERT_NEXT(a_free_only_grows_on_restart, !(in_fire && in_data_i.op == tlv_enc_pkg::OpRestart), free_q <= $past(free_q), "free space grew without a restart")
  `TLV_ASSERT_NOW(a_single_result_for_status, q_push_o && q_data_o.status != tlv_enc_pkg::StatusByte, q_data_o.count == tlv_enc_pkg::CountW'(1), "status entry with more than one result")

endmodule

@@ design/tlv_enc_fifo.sv @@
// ----------------------------------------------------------------------------
// TLV encoder element queue
// Small register queue of encoded elements between front and back end.
// ----------------------------------------------------------------------------
module tlv_enc_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  tlv_enc_pkg::desc_t push_data_i,
  input  logic               pop_i,
  output tlv_enc_pkg::desc_t head_o,
  output logic               empty_o,
  output logic               full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  tlv_enc_pkg::desc_t entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign empty_o = (count_q == CntW'(0));
  assign full_o  = (count_q == CntW'(Depth));
  assign head_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

`include "tlv_element_header_encoder_assert.svh"

  `TLV_ASSERT_NOW(a_count_bounded, 1'b1, count_q <= CntW'(Depth), "queue count exceeds depth")
  `TLV_ASSERT_NOW(a_no_pop_when_empty, empty_o, !pop_i, "pop from an empty queue")

endmodule

@@ design/tlv_enc_back.sv @@
// ----------------------------------------------------------------------------
// TLV encoder back end
// Sends the head element of the queue one byte per transfer.
// ----------------------------------------------------------------------------
module tlv_enc_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tlv_enc_pkg::desc_t     head_i,
  input  logic                   empty_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output tlv_enc_pkg::out_item_t out_data_o
);

  logic [tlv_enc_pkg::CountW-1:0] idx_q, idx_d;
  logic                           valid_q, valid_d;
  tlv_enc_pkg::out_item_t         out_q, out_d;
  logic                           load;
  logic                           is_last;

  assign load    = !empty_i && (!valid_q || out_ready_i);
  assign is_last = (idx_q == head_i.count - tlv_enc_pkg::CountW'(1));
  assign pop_o   = load && is_last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    out_d   = out_q;
    if (load) begin
      valid_d         = 1'b1;
      out_d.data_byte = head_i.bytes[idx_q];
      out_d.status    = head_i.status;
      out_d.last      = is_last;
      idx_d           = is_last ? '0 : idx_q + tlv_enc_pkg::CountW'(1);
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = out_q;

`include "tlv_element_header_encoder_assert.svh"

  `TLV_ASSERT_NOW(a_index_in_element, !empty_i, idx_q < head_i.count, "byte index beyond element")

endmodule

@@ design/tlv_element_header_encoder.sv @@
// ----------------------------------------------------------------------------
// TLV element header encoder
// Encodes TLV type-length headers and integer elements as VAR-NUMBER bytes.
// ----------------------------------------------------------------------------
// An element of n bytes (n from 2 to 10) leaves as n transfers on the result
// channel, one byte per cycle while the output is ready, in final memory order;
// a restart or an element that does not fit gives a single transfer with its
// status and last set. The input side takes one item per cycle as long as the
// element queue (QueueDepth entries) has room, so the sustained rate is set by
// the byte serializer of the back end, which sends an element byte by byte and
// a restart or no-fit result as one transfer. An accepted item is queued and
// then loaded into the output register. Op 3 is accepted and produces nothing.
// The free-space count is updated when an item is accepted, so items are
// checked in order even while earlier elements are still being sent.
// A capacity write takes effect at the next restart.
module tlv_element_header_encoder #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [15:0]            cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  tlv_enc_pkg::in_item_t  in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output tlv_enc_pkg::out_item_t out_data_o
);

  // Element queue signals between the front and the back end.
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  tlv_enc_pkg::desc_t q_wdata;
  tlv_enc_pkg::desc_t q_head;

  // The front end classifies each item, checks elements against the free space
  // and queues either the finished byte string or a status entry; op 3 queues nothing.
  tlv_enc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  tlv_enc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  // The back end walks through the head element and releases it from the
  // queue when its last byte moves into the output register.
  tlv_enc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// TLV element header encoder testbench
// Drives header, integer, restart and undefined items through the encoder and
// checks every output byte against typed-in results or a VAR-NUMBER predictor
// in the bench, over several capacities and with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;

  // The package names three operations; the fourth code is accepted by the
  // block and produces nothing.
  localparam logic [1:0] OpUndefined = 2'd3;

  // Generous bound on the length of a full run.
  localparam int unsigned CycleLimit = 200000;

  // One row of directed stimulus. A row either writes the capacity register or
  // sends one item. When pinned_count is nonzero the row carries its own
  // expected output (pinned_bytes right-aligned, first byte most significant);
  // otherwise the prediction is used.
  typedef struct {
    bit                    cfg_write;
    logic [15:0]           cfg_value;
    tlv_enc_pkg::in_item_t item;
    int unsigned           pinned_count;
    logic [79:0]           pinned_bytes;
    logic [1:0]            pinned_status;
  } stim_row_t;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_we_i    = 1'b0;
  logic [15:0]            cfg_wdata_i = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_ready_o;
  tlv_enc_pkg::in_item_t  in_data_i   = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  tlv_enc_pkg::out_item_t out_data_o;

  // Predictor state: its own copy of the free-space count and the register.
  logic [15:0] free_space    = tlv_enc_pkg::CapacityReset;
  logic [15:0] capacity_copy = tlv_enc_pkg::CapacityReset;

  // Scratch for encoding one element.
  logic [7:0]             enc_bytes [0:9];
  int                     enc_len;
  tlv_enc_pkg::out_item_t predicted [$];

  // Bytes and status transfers still owed by the encoder, oldest first.
  tlv_enc_pkg::out_item_t encoder_output_q [$];
  // Rows of items that have been driven but not yet accepted, in order.
  stim_row_t   pinned_q [$];
  stim_row_t   directed_rows [$];

  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;
  int unsigned in_idle_pct  = 20;
  int unsigned out_idle_pct = 20;

  tlv_element_header_encoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  // Run-length guard. A hang anywhere ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Every mismatch prints one line and is counted.
  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH cycle %0d: %s", cycle_count, msg);
  endtask

  // Appends one VAR-NUMBER to the scratch buffer: one byte below 253, else a
  // marker followed by two or four big-endian bytes.
  function automatic void append_number(logic [31:0] v);
    if (v < 32'd253) begin
      enc_bytes[enc_len] = v[7:0];
      enc_len++;
    end else if (v[31:16] == 16'd0) begin
      enc_bytes[enc_len]     = tlv_enc_pkg::Mark2;
      enc_bytes[enc_len + 1] = v[15:8];
      enc_bytes[enc_len + 2] = v[7:0];
      enc_len += 3;
    end else begin
      enc_bytes[enc_len]     = tlv_enc_pkg::Mark4;
      enc_bytes[enc_len + 1] = v[31:24];
      enc_bytes[enc_len + 2] = v[23:16];
      enc_bytes[enc_len + 3] = v[15:8];
      enc_bytes[enc_len + 4] = v[7:0];
      enc_len += 5;
    end
  endfunction

  // Works out the transfers that one accepted item causes and advances the
  // free-space count. An element that does not fit leaves the count alone.
  function automatic void encode_item(tlv_enc_pkg::in_item_t it);
    int vlen;
    int i;
    tlv_enc_pkg::out_item_t r;
    predicted.delete();
    enc_len = 0;
    case (it.op)
      tlv_enc_pkg::OpRestart: begin
        free_space = capacity_copy;
        r = '{data_byte: 8'd0, status: tlv_enc_pkg::StatusRestart, last: 1'b1};
        predicted.push_back(r);
      end
      tlv_enc_pkg::OpHeader, tlv_enc_pkg::OpInteger: begin
        append_number({1'b0, it.elem_type});
        if (it.op == tlv_enc_pkg::OpHeader) begin
          append_number(it.length);
        end else begin
          // The value is padded to 1, 2 or 4 bytes; zero is a single 0x00.
          if (it.value[31:16] != 16'd0) vlen = 4;
          else if (it.value[15:8] != 8'd0) vlen = 2;
          else vlen = 1;
          append_number(32'(vlen));
          for (i = vlen - 1; i >= 0; i--) begin
            enc_bytes[enc_len] = it.value[8*i +: 8];
            enc_len++;
          end
        end
        if (enc_len > int'(free_space)) begin
          r = '{data_byte: 8'd0, status: tlv_enc_pkg::StatusNoFit, last: 1'b1};
          predicted.push_back(r);
        end else begin
          free_space = free_space - 16'(enc_len);
          for (i = 0; i < enc_len; i++) begin
            r = '{data_byte: enc_bytes[i], status: tlv_enc_pkg::StatusByte,
                  last: (i == enc_len - 1)};
            predicted.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Monitor. Inputs and outputs are sampled at the rising edge, before any
  // nonblocking update of that edge lands, so each value seen is the one that
  // took part in the handshake. Accepted items feed the predictor first; then
  // an accepted result is compared with the oldest expectation.
  always @(posedge clk_i) begin : monitor
    stim_row_t row;
    tlv_enc_pkg::out_item_t want;
    int i;
    if (rst_ni) begin
      if (cfg_we_i) capacity_copy = cfg_wdata_i;
      if (in_valid_i && in_ready_o) begin
        row = pinned_q.pop_front();
        encode_item(in_data_i);
        if (row.pinned_count == 0) begin
          foreach (predicted[k]) encoder_output_q.push_back(predicted[k]);
        end else if (row.pinned_status != tlv_enc_pkg::StatusByte) begin
          want = '{data_byte: 8'd0, status: row.pinned_status, last: 1'b1};
          encoder_output_q.push_back(want);
        end else begin
          for (i = 0; i < int'(row.pinned_count); i++) begin
            want.data_byte = row.pinned_bytes[8*(int'(row.pinned_count) - 1 - i) +: 8];
            want.status    = tlv_enc_pkg::StatusByte;
            want.last      = (i == int'(row.pinned_count) - 1);
            encoder_output_q.push_back(want);
          end
        end
      end
      if (out_valid_o && out_ready_i) begin
        if (encoder_output_q.size() == 0) begin
          report_mismatch($sformatf("transfer with nothing pending: byte %0h status %0d last %0d",
                                    out_data_o.data_byte, out_data_o.status, out_data_o.last));
        end else begin
          want = encoder_output_q.pop_front();
          if (out_data_o.data_byte !== want.data_byte)
            report_mismatch($sformatf("data_byte %0h, expected %0h",
                                      out_data_o.data_byte, want.data_byte));
          if (out_data_o.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_data_o.status, want.status));
          if (out_data_o.last !== want.last)
            report_mismatch($sformatf("last %0d, expected %0d",
                                      out_data_o.last, want.last));
        end
      end
    end
  end

  // Result side back-pressure: ready drops at random about a fifth of the time
  // unless the stimulus has switched idling off for a stretch.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(1, 100) > out_idle_pct);
  end

  // Offers one item, with random idle cycles ahead of it. Valid is left high
  // after the transfer so that a following item goes out back to back; the
  // next call or the drain lowers it if needed.
  task automatic send_item(input stim_row_t row);
    while (in_idle_pct != 0 && $urandom_range(1, 100) <= in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    pinned_q.push_back(row);
    in_valid_i <= 1'b1;
    in_data_i  <= row.item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Waits until every expected transfer has arrived. The first edge is always
  // taken so the monitor has seen the last input transfer.
  task automatic drain_outputs();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (encoder_output_q.size() != 0);
  endtask

  // The register is only written with the block idle. An undefined op leaves
  // nothing to wait for, so the task idles on after the drain to cover anything in flight.
  task automatic write_capacity(input logic [15:0] value);
    drain_outputs();
    repeat (8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic void item_row(logic [1:0] op, logic [30:0] typ, logic [31:0] len,
                                   logic [31:0] val, int unsigned n, logic [79:0] bytes,
                                   logic [1:0] st);
    stim_row_t row;
    row.cfg_write     = 1'b0;
    row.cfg_value     = '0;
    row.item          = '{op: op, elem_type: typ, length: len, value: val};
    row.pinned_count  = n;
    row.pinned_bytes  = bytes;
    row.pinned_status = st;
    directed_rows.push_back(row);
  endfunction

  function automatic void cfg_row(logic [15:0] value);
    stim_row_t row;
    row           = '{default: '0};
    row.cfg_write = 1'b1;
    row.cfg_value = value;
    directed_rows.push_back(row);
  endfunction

  // Numbers spread over the VAR-NUMBER size classes, with the boundaries
  // between them picked out on purpose.
  function automatic logic [31:0] pick_number();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 252);
      1: return $urandom_range(253, 65535);
      2: return $urandom_range(32'h10000, 32'hFFFFFF);
      3: begin
        case ($urandom_range(0, 7))
          0: return 32'd0;
          1: return 32'd252;
          2: return 32'd253;
          3: return 32'd255;
          4: return 32'd256;
          5: return 32'hFFFF;
          6: return 32'h10000;
          default: return 32'hFFFFFFFF;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic stim_row_t random_row(bit restart);
    stim_row_t row;
    int unsigned pick;
    logic [31:0] typ;
    row  = '{default: '0};
    pick = $urandom_range(0, 99);
    if (restart || pick >= 88 && pick < 97) row.item.op = tlv_enc_pkg::OpRestart;
    else if (pick < 44) row.item.op = tlv_enc_pkg::OpHeader;
    else if (pick < 88) row.item.op = tlv_enc_pkg::OpInteger;
    else row.item.op = OpUndefined;
    typ                = pick_number();
    row.item.elem_type = typ[30:0];
    row.item.length    = pick_number();
    row.item.value     = pick_number();
    return row;
  endfunction

  initial begin : stimulus
    int unsigned phase;
    int unsigned n;
    logic [15:0] cap;

    // Directed table. Byte results are typed in where they can be read off
    // directly; the rest come from the predictor.
    item_row(tlv_enc_pkg::OpHeader, 31'd0, 32'd0, 32'd0, 2, 80'h0000,
             tlv_enc_pkg::StatusByte);
    item_row(tlv_enc_pkg::OpHeader, 31'd252, 32'd252, 32'd0, 2, 80'hFCFC,
             tlv_enc_pkg::StatusByte);
    item_row(tlv_enc_pkg::OpHeader, 31'd253, 32'hFFFF, 32'd0, 6, 80'hFD00FDFDFFFF,
             tlv_enc_pkg::StatusByte);
    item_row(tlv_enc_pkg::OpHeader, 31'h7FFFFFFF, 32'hFFFFFFFF, 32'd0, 10,
             80'hFE7FFFFFFFFEFFFFFFFF, tlv_enc_pkg::StatusByte);
    item_row(tlv_enc_pkg::OpHeader, 31'h10000, 32'h10000, 32'hFFFFFFFF, 0, '0,
             tlv_enc_pkg::StatusByte);
    item_row(tlv_enc_pkg::OpInteger, 31'd7, 32'hFFFFFFFF, 32'd0, 3, 80'h070100,
             tlv_enc_pkg::StatusByte);
    item_row(tlv_enc_pkg::OpInteger, 31'd7, 32'd0, 32'hFF, 0, '0, tlv_enc_pkg::StatusByte);
    item_row(tlv_enc_pkg::OpInteger, 31'd7, 32'd0, 32'h100, 0, '0, tlv_enc_pkg::StatusByte);
    item_row(tlv_enc_pkg::OpInteger, 31'd7, 32'd0, 32'hFFFF, 0, '0, tlv_enc_pkg::StatusByte);
    // Three significant bytes are padded out to four.
    item_row(tlv_enc_pkg::OpInteger, 31'd7, 32'd0, 32'h10000, 0, '0,
             tlv_enc_pkg::StatusByte);
    item_row(tlv_enc_pkg::OpInteger, 31'h7FFFFFFF, 32'd0, 32'hFFFFFFFF, 10,
             80'hFE7FFFFFFF04FFFFFFFF, tlv_enc_pkg::StatusByte);
    // An undefined op is swallowed without any transfer.
    item_row(OpUndefined, 31'h2AAAAAAA, 32'hA5A5A5A5, 32'h5A5A5A5A, 0, '0,
             tlv_enc_pkg::StatusByte);
    item_row(tlv_enc_pkg::OpRestart, 31'd0, 32'd0, 32'd0, 1, '0,
             tlv_enc_pkg::StatusRestart);
    // Small buffer: fill it to exactly zero, with a no-fit in between.
    cfg_row(16'd12);
    item_row(tlv_enc_pkg::OpRestart, 31'd5, 32'd5, 32'd5, 1, '0,
             tlv_enc_pkg::StatusRestart);
    item_row(tlv_enc_pkg::OpHeader, 31'h7FFFFFFF, 32'hFFFFFFFF, 32'd0, 0, '0,
             tlv_enc_pkg::StatusByte);
    item_row(tlv_enc_pkg::OpInteger, 31'd1, 32'd0, 32'd1, 1, '0, tlv_enc_pkg::StatusNoFit);
    item_row(tlv_enc_pkg::OpHeader, 31'd0, 32'd0, 32'd0, 2, 80'h0000,
             tlv_enc_pkg::StatusByte);
    item_row(tlv_enc_pkg::OpHeader, 31'd0, 32'd0, 32'd0, 1, '0, tlv_enc_pkg::StatusNoFit);
    // Zero capacity: nothing ever fits.
    cfg_row(16'd0);
    item_row(tlv_enc_pkg::OpRestart, 31'd0, 32'd0, 32'd0, 1, '0,
             tlv_enc_pkg::StatusRestart);
    item_row(tlv_enc_pkg::OpInteger, 31'd0, 32'd0, 32'd0, 1, '0, tlv_enc_pkg::StatusNoFit);
    // A capacity write only takes effect at the next restart.
    cfg_row(16'hFFFF);
    item_row(tlv_enc_pkg::OpHeader, 31'd0, 32'd0, 32'd0, 1, '0, tlv_enc_pkg::StatusNoFit);
    item_row(tlv_enc_pkg::OpRestart, 31'd0, 32'd0, 32'd0, 1, '0,
             tlv_enc_pkg::StatusRestart);
    item_row(tlv_enc_pkg::OpInteger, 31'd253, 32'd0, 32'h12345, 0, '0,
             tlv_enc_pkg::StatusByte);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg_write) write_capacity(directed_rows[i].cfg_value);
      else send_item(directed_rows[i]);
    end

    // Random part in phases, each under its own capacity and opened with a
    // restart so that the new capacity is in force. Two phases run with no
    // idling on either side.
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: cap = 16'hFFFF;
        1: cap = 16'd0;
        2: cap = 16'($urandom_range(1, 24));
        3: cap = 16'($urandom_range(0, 65535));
        4: cap = tlv_enc_pkg::CapacityReset;
        5: cap = 16'($urandom_range(10, 40));
        6: cap = 16'($urandom_range(1, 12));
        default: cap = 16'($urandom_range(2, 64));
      endcase
      write_capacity(cap);
      if (phase == 3 || phase == 4) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct  = 20;
        out_idle_pct = 20;
      end
      for (n = 0; n < 37; n++) send_item(random_row(n == 0));
    end

    drain_outputs();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
